FILE: src/hid_pkg.sv
// Shared types and constants for the handle/id translation table.
package hid_pkg;

    localparam int KIND_W = 2;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEREF  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd3;

    // Lowest id that is ever issued
    localparam logic [DATA_W-1:0] ID_FLOOR = 64'd1024;

    // Entry word layout: {valid, id, handle}
    localparam int ENTRY_W = 2 * DATA_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_RESP
    } t_state;

endpackage

FILE: src/hid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/handle_id_translation_table.sv
// Top level of the handle/id translation table: sequencer, shared compare unit and entry RAM.
// Each request is one transaction in and one transaction out. Entries sit in a single RAM
// that is scanned one entry per cycle through one shared 64-bit comparator. A request that
// issues a new id runs a second scan to check that the issued id is not already held. A
// zero operand is answered in the cycle after acceptance. The block takes no new request
// until its result has been taken. After reset a clearing pass writes every RAM entry
// invalid, one per cycle, before the block is ready.
module handle_id_translation_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hid_pkg::KIND_W-1:0]  i_kind,
    input  logic [hid_pkg::DATA_W-1:0]  i_operand,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hid_pkg::DATA_W-1:0]  o_answer,
    output logic [hid_pkg::STAT_W-1:0]  o_status
);

    import hid_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;

    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_op;
    logic [DATA_W-1:0] r_new_id;
    logic [DATA_W-1:0] r_counter;
    logic              r_check;
    logic [CW-1:0]     r_cnt;
    logic              r_pend;
    logic [AW-1:0]     r_ridx;
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [DATA_W-1:0] r_hit_data;
    logic              r_free_found;
    logic [AW-1:0]     r_free_idx;
    logic [DATA_W-1:0] r_answer;
    logic [STAT_W-1:0] r_status;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              in_accept;
    logic              scan_issue;
    logic              scan_done;
    logic              by_id;
    logic [DATA_W-1:0] search_key;
    logic              ent_valid;
    logic [DATA_W-1:0] ent_id;
    logic [DATA_W-1:0] ent_handle;
    logic              cmp_hit;
    logic [DATA_W-1:0] issued_id;

    // Result of the evaluate step
    logic              e_start_check;
    logic [DATA_W-1:0] e_answer;
    logic [STAT_W-1:0] e_status;
    logic              e_we;
    logic [AW-1:0]     e_waddr;
    logic [ENTRY_W-1:0] e_wdata;

    hid_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Handshake and scan control
    assign in_accept  = i_valid && !o_stall;
    assign scan_issue = (r_state == S_SCAN) && (r_cnt != CNT_END);
    assign scan_done  = (r_state == S_SCAN) && (r_cnt == CNT_END) && !r_pend;

    // Shared compare unit: handle search, or id search for deref, remove and the issued-id check
    assign by_id      = r_check || r_kind[1];
    assign search_key = r_check ? r_new_id : r_op;
    assign ent_valid  = ram_rdata[ENTRY_W-1];
    assign ent_id     = ram_rdata[2*DATA_W-1:DATA_W];
    assign ent_handle = ram_rdata[DATA_W-1:0];
    assign cmp_hit    = ent_valid && ((by_id ? ent_id : ent_handle) == search_key);

    // Next id: counter value raised to the floor
    assign issued_id = (r_counter < ID_FLOOR) ? ID_FLOOR : r_counter;

    // Evaluate step after a scan
    always_comb begin
        e_start_check = 1'b0;
        e_answer      = '0;
        e_status      = STAT_OK;
        e_we          = 1'b0;
        e_waddr       = r_hit_idx;
        e_wdata       = '0;
        if (r_check) begin
            if (r_hit) begin
                e_status = STAT_DUPLICATE;
            end else begin
                e_we     = 1'b1;
                e_waddr  = r_free_idx;
                e_wdata  = {1'b1, r_new_id, r_op};
                e_answer = r_new_id;
            end
        end else begin
            case (r_kind)
                KIND_DEREF, KIND_REMOVE: begin
                    if (r_hit) begin
                        e_answer = r_hit_data;
                        e_we     = (r_kind == KIND_REMOVE);
                    end else begin
                        e_status = STAT_NOT_FOUND;
                    end
                end
                KIND_INSERT, KIND_LOOKUP: begin
                    if (r_hit) begin
                        if (r_kind == KIND_LOOKUP) begin
                            e_answer = r_hit_data;
                        end else begin
                            e_status = STAT_DUPLICATE;
                        end
                    end else if (!r_free_found) begin
                        e_status = STAT_FULL;
                    end else begin
                        e_start_check = 1'b1;
                    end
                end
                default: begin
                    e_status = STAT_OK;
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_operand == '0) ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = e_start_check ? S_SCAN : S_RESP;
            end
            S_RESP: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs and RAM write port
    always_comb begin
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_EVAL: begin
                ram_we    = e_we;
                ram_waddr = e_waddr;
                ram_wdata = e_wdata;
            end
            S_RESP: begin
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign o_answer = r_answer;
    assign o_status = r_status;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_check      <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_counter    <= ID_FLOOR;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                S_IDLE: begin
                    r_cnt        <= '0;
                    r_pend       <= 1'b0;
                    r_check      <= 1'b0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pend && cmp_hit && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (r_pend && !ent_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end
                S_EVAL: begin
                    if (e_start_check) begin
                        r_check   <= 1'b1;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_counter <= issued_id + 64'd1;
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind   <= i_kind;
            r_op     <= i_operand;
            r_answer <= '0;
            r_status <= STAT_OK;
        end
        // Index of the entry whose read data arrives next cycle
        if (scan_issue) begin
            r_ridx <= r_cnt[AW-1:0];
        end
        if (r_state == S_SCAN && r_pend && cmp_hit && !r_hit) begin
            r_hit_idx  <= r_ridx;
            r_hit_data <= by_id ? ent_handle : ent_id;
        end
        if (r_state == S_SCAN && r_pend && !ent_valid && !r_free_found) begin
            r_free_idx <= r_ridx;
        end
        if (r_state == S_EVAL) begin
            if (e_start_check) begin
                r_new_id <= issued_id;
            end else begin
                r_answer <= e_answer;
                r_status <= e_status;
            end
        end
    end

`ifndef SYNTHESIS
    // A result on offer blocks new requests
    a_resp_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while input is open");

    // The table is only written during clearing or at the end of a scan
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_EVAL))
        else $error("entry RAM written outside clearing or evaluate");

    // Any error status carries a zero answer
    a_error_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_answer == '0))
        else $error("error result with nonzero answer");

    // A zero operand is answered in the next cycle
    a_zero_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operand == '0) |=> (o_valid && o_answer == '0))
        else $error("zero operand not passed through");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the handle/id translation table.
`timescale 1ns / 1ps

module testbench;
    import hid_pkg::*;

    localparam int  TABLE_ENTRIES = 64;
    localparam int  RANDOM_ITEMS  = 1000;
    localparam int  MAX_REPORTS   = 40;
    // Watchdog: bound on the slowest correct run of roughly 1200 items at a 20 ns clock period
    localparam real WATCHDOG_NS   = 40_000_000.0;

    typedef struct {
        logic [DATA_W-1:0] answer;
        logic [STAT_W-1:0] status;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind;
    logic [DATA_W-1:0] i_operand;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_answer;
    logic [STAT_W-1:0] o_status;

    // Mirror of the translation table
    logic [DATA_W-1:0] tbl_handle [TABLE_ENTRIES];
    logic [DATA_W-1:0] tbl_id     [TABLE_ENTRIES];
    logic              tbl_valid  [TABLE_ENTRIES];
    logic [DATA_W-1:0] tbl_next_id;

    t_result           pending_results [$];
    logic [DATA_W-1:0] retired_ids [$];
    int                error_count;
    int                result_count;
    int                kind_count   [4];
    int                status_count [4];
    bit                no_idle;

    handle_id_translation_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_kind    (i_kind),
        .i_operand (i_operand),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_answer  (o_answer),
        .o_status  (o_status)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout: %0d results still outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // ---------------------------------------------------------------
    // Table predictor
    // ---------------------------------------------------------------
    function automatic int find_handle(input logic [DATA_W-1:0] h);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_handle[i] == h) return i;
        end
        return -1;
    endfunction

    function automatic int find_id(input logic [DATA_W-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) n++;
        end
        return n;
    endfunction

    // Store a pair for an absent handle, issuing the next id, or report a full table or a held id
    function automatic void issue_id(input logic [DATA_W-1:0] h,
                                     output logic [DATA_W-1:0] ans,
                                     output logic [STAT_W-1:0] st);
        int                slot;
        logic [DATA_W-1:0] id;
        slot = -1;
        ans  = '0;
        st   = STAT_OK;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
            st = STAT_FULL;
            return;
        end
        id = (tbl_next_id < ID_FLOOR) ? ID_FLOOR : tbl_next_id;
        tbl_next_id = id + 64'd1;
        // Id still held after a counter wrap: id is burned
        if (find_id(id) >= 0) begin
            st = STAT_DUPLICATE;
            return;
        end
        tbl_handle[slot] = h;
        tbl_id[slot]     = id;
        tbl_valid[slot]  = 1'b1;
        ans              = id;
    endfunction

    function automatic t_result predict_request(input logic [KIND_W-1:0] kind,
                                                input logic [DATA_W-1:0] op);
        t_result res;
        int      idx;
        res.answer = '0;
        res.status = STAT_OK;
        // Zero operand passes straight through
        if (op != '0) begin
            case (kind)
                KIND_INSERT: begin
                    if (find_handle(op) >= 0) res.status = STAT_DUPLICATE;
                    else issue_id(op, res.answer, res.status);
                end
                KIND_LOOKUP: begin
                    idx = find_handle(op);
                    if (idx >= 0) res.answer = tbl_id[idx];
                    else issue_id(op, res.answer, res.status);
                end
                default: begin
                    idx = find_id(op);
                    if (idx < 0) begin
                        res.status = STAT_NOT_FOUND;
                    end else begin
                        res.answer = tbl_handle[idx];
                        if (kind == KIND_REMOVE) tbl_valid[idx] = 1'b0;
                    end
                end
            endcase
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Nonzero handle not held by the table; small values now and then
    function automatic logic [DATA_W-1:0] fresh_handle();
        logic [DATA_W-1:0] h;
        do begin
            if ($urandom_range(0, 4) == 0) h = DATA_W'($urandom_range(1, 1023));
            else h = {$urandom(), $urandom()};
        end while (h == '0 || find_handle(h) >= 0);
        return h;
    endfunction

    // Random live slot, or -1 when the table is empty
    function automatic int pick_live_slot();
        int n;
        int pick;
        n = live_count();
        if (n == 0) return -1;
        pick = $urandom_range(0, n - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (pick == 0) return i;
                pick--;
            end
        end
        return -1;
    endfunction

    // Send one request transaction; returns at the accepting edge
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [DATA_W-1:0] op);
        int      gap;
        t_result res;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_operand <= op;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        res = predict_request(kind, op);
        pending_results.push_back(res);
        kind_count[kind]++;
        status_count[res.status]++;
        if (kind == KIND_REMOVE && res.status == STAT_OK) begin
            retired_ids.push_back(op);
            if (retired_ids.size() > 16) void'(retired_ids.pop_front());
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    initial begin
        t_result exp_res;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if ($isunknown(o_valid)) begin
                    report_mismatch("o_valid is unknown");
                end else if (o_valid && i_stall === 1'b0) begin
                    result_count++;
                    if (pending_results.size() == 0) begin
                        report_mismatch($sformatf("unexpected result answer=%h status=%0d",
                                                  o_answer, o_status));
                    end else begin
                        exp_res = pending_results.pop_front();
                        if (o_answer !== exp_res.answer)
                            report_mismatch($sformatf("result %0d answer %h, expected %h",
                                                      result_count, o_answer, exp_res.answer));
                        if (o_status !== exp_res.status)
                            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                      result_count, o_status, exp_res.status));
                    end
                end
            end
        end
    end

    // Result-side backpressure
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_cnt > 0) begin
                i_stall <= 1'b1;
                stall_cnt--;
            end else begin
                i_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 7) == 0) stall_cnt = gap_len();
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_zero_operand();
        send_request(KIND_INSERT, '0);
        send_request(KIND_LOOKUP, '0);
        send_request(KIND_DEREF,  '0);
        send_request(KIND_REMOVE, '0);
    endtask

    task automatic test_basic_ops();
        send_request(KIND_INSERT, '1);                    // all-ones handle
        send_request(KIND_INSERT, 64'd1);
        send_request(KIND_DEREF,  ID_FLOOR);
        send_request(KIND_DEREF,  ID_FLOOR + 64'd1);
        send_request(KIND_LOOKUP, '1);                    // existing entry
        send_request(KIND_LOOKUP, 64'h8000_0000_0000_0000); // absent, inserts
        send_request(KIND_INSERT, 64'd1);                 // duplicate handle
        send_request(KIND_DEREF,  '1);                    // unknown id
        send_request(KIND_DEREF,  ID_FLOOR - 64'd1);      // below the id floor
        send_request(KIND_REMOVE, ID_FLOOR);
        send_request(KIND_DEREF,  ID_FLOOR);              // removed
        send_request(KIND_REMOVE, ID_FLOOR);              // removed twice
        send_request(KIND_INSERT, '1);                    // reinsert gets a new id
    endtask

    // Fill to capacity, hit the full and existing-handle cases, then empty in random order
    task automatic test_fill_and_drain();
        int slot;
        while (live_count() < TABLE_ENTRIES) begin
            send_request($urandom_range(0, 1) ? KIND_LOOKUP : KIND_INSERT, fresh_handle());
        end
        send_request(KIND_INSERT, fresh_handle());
        send_request(KIND_LOOKUP, fresh_handle());
        slot = pick_live_slot();
        send_request(KIND_LOOKUP, tbl_handle[slot]);
        send_request(KIND_INSERT, tbl_handle[slot]);
        while (live_count() > 0) begin
            slot = pick_live_slot();
            if ($urandom_range(0, 3) == 0) send_request(KIND_DEREF, tbl_id[slot]);
            send_request(KIND_REMOVE, tbl_id[slot]);
        end
    endtask

    task automatic test_random_traffic();
        bit                filling;
        int                r;
        int                slot;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] op;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Burst with no idling on either side now and then
            no_idle = (n % 200) >= 150;
            if (live_count() >= TABLE_ENTRIES && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (live_count() <= 2) filling = 1'b1;
            slot = pick_live_slot();
            r = $urandom_range(0, 99);
            if (r < 3) begin
                kind = KIND_W'($urandom_range(0, 3));
                op   = '0;
            end else if (r < 9) begin
                // noise: arbitrary operand
                kind = KIND_W'($urandom_range(0, 3));
                op   = {$urandom(), $urandom()};
            end else begin
                r = $urandom_range(0, 99);
                if (slot < 0) r = 0;
                if (filling) begin
                    if (r < 35)      begin kind = KIND_INSERT; op = fresh_handle();    end
                    else if (r < 50) begin kind = KIND_LOOKUP; op = fresh_handle();    end
                    else if (r < 65) begin kind = KIND_LOOKUP; op = tbl_handle[slot]; end
                    else if (r < 75) begin kind = KIND_INSERT; op = tbl_handle[slot]; end
                    else if (r < 90) begin kind = KIND_DEREF;  op = tbl_id[slot];     end
                    else             begin kind = KIND_REMOVE; op = tbl_id[slot];     end
                end else begin
                    if (r < 10)      begin kind = KIND_INSERT; op = fresh_handle();    end
                    else if (r < 15) begin kind = KIND_LOOKUP; op = fresh_handle();    end
                    else if (r < 30) begin kind = KIND_LOOKUP; op = tbl_handle[slot]; end
                    else if (r < 50) begin kind = KIND_DEREF;  op = tbl_id[slot];     end
                    else if (r < 90) begin kind = KIND_REMOVE; op = tbl_id[slot];     end
                    else begin
                        // stale id from an earlier removal
                        kind = $urandom_range(0, 1) ? KIND_DEREF : KIND_REMOVE;
                        op   = (retired_ids.size() > 0)
                             ? retired_ids[$urandom_range(0, retired_ids.size() - 1)]
                             : {$urandom(), $urandom()};
                    end
                end
            end
            send_request(kind, op);
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        error_count  = 0;
        result_count = 0;
        no_idle      = 1'b0;
        for (int i = 0; i < 4; i++) begin
            kind_count[i]   = 0;
            status_count[i] = 0;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_handle[i] = '0;
            tbl_id[i]     = '0;
            tbl_valid[i]  = 1'b0;
        end
        tbl_next_id = ID_FLOOR;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_kind    <= KIND_INSERT;
        i_operand <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_operand();
        test_basic_ops();
        test_fill_and_drain();
        test_random_traffic();

        // Drain and watch for stray results
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_ENTRIES + 16) @(posedge i_clk);

        $display("Requests: %0d insert, %0d lookup-or-insert, %0d deref, %0d remove",
                 kind_count[KIND_INSERT], kind_count[KIND_LOOKUP],
                 kind_count[KIND_DEREF], kind_count[KIND_REMOVE]);
        $display("Outcomes: %0d ok, %0d id not found, %0d table full, %0d duplicate; %0d errors",
                 status_count[STAT_OK], status_count[STAT_NOT_FOUND],
                 status_count[STAT_FULL], status_count[STAT_DUPLICATE], error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/hid_pkg.sv
src/hid_ram.sv
src/handle_id_translation_table.sv
dv/testbench.sv
